/* rtl/core/nfca_pkg.sv */
// Shared types, codes and constants of the ISO14443A activation block.
package nfca_pkg;

  localparam int MAX_CASCADE_LEVELS = 3;
  localparam int UID_MAX_BYTES      = 10;
  localparam int UID_BITS           = 8 * UID_MAX_BYTES;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Input modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_RX    = 2'd1;

  // Transmit frame kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SENS = 2'd1;
  localparam logic [1:0] KIND_SDD  = 2'd2;
  localparam logic [1:0] KIND_STD  = 2'd3;

  // Final status codes
  localparam logic [2:0] STAT_BUSY      = 3'd0;
  localparam logic [2:0] STAT_ACTIVE    = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_COMM_ERR  = 3'd3;
  localparam logic [2:0] STAT_COLL_FAIL = 3'd4;

  // Configuration register indexes
  localparam logic REG_CASCADE_TAG = 1'b0;
  localparam logic REG_SELECT_BASE = 1'b1;

  localparam logic [7:0] CASCADE_TAG_RESET = 8'd136;
  localparam logic [7:0] SELECT_BASE_RESET = 8'd147;

  // Frame bytes
  localparam logic [7:0] HLTA_B0 = 8'h50;
  localparam logic [7:0] HLTA_B1 = 8'h00;
  localparam logic [7:0] SDD_PAR = 8'h20;
  localparam logic [7:0] SEL_PAR = 8'h70;

  localparam logic [2:0] LEN_HLTA = 3'd2;
  localparam logic [2:0] LEN_SDD  = 3'd2;
  localparam logic [2:0] LEN_SEL  = 3'd7;

  // Poller phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HALT   = 3'd1;
  localparam logic [2:0] PH_SENS   = 3'd2;
  localparam logic [2:0] PH_SDD    = 3'd3;
  localparam logic [2:0] PH_SEL    = 3'd4;
  localparam logic [2:0] PH_ACTIVE = 3'd5;
  localparam logic [2:0] PH_FAILED = 3'd6;

  // Classified transfer outcome passed from front to back
  typedef struct packed {
    logic        start;
    logic        got;
    logic        len_one;
    logic        len_two;
    logic        len_five;
    logic        crc_ok;
    logic [39:0] rx_data;
  } cls_t;

endpackage

/* rtl/core/nfca_ifs.sv */
// Valid/ready channel interfaces for transfer outcomes and poller results.
interface nfca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  rx_len;
  logic [39:0] rx_data;
  logic        crc_ok;

  modport source (output valid, mode, rx_len, rx_data, crc_ok, input ready);
  modport sink   (input valid, mode, rx_len, rx_data, crc_ok, output ready);
endinterface

interface nfca_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tx_kind;
  logic [2:0]  tx_len;
  logic [55:0] tx_data;
  logic [2:0]  status;
  logic [63:0] uid_low_bytes;
  logic [15:0] uid_high_bytes;
  logic [3:0]  uid_length;
  logic [7:0]  sak_value;
  logic [15:0] atqa_value;

  modport source (output valid, tx_kind, tx_len, tx_data, status, uid_low_bytes,
                  uid_high_bytes, uid_length, sak_value, atqa_value, input ready);
  modport sink   (input valid, tx_kind, tx_len, tx_data, status, uid_low_bytes,
                  uid_high_bytes, uid_length, sak_value, atqa_value, output ready);
endinterface

/* rtl/core/nfca_front.sv */
// Front end: accept transfer outcomes and classify them for the queue.
module nfca_front import nfca_pkg::*; (
  nfca_in_if.sink in_ch,
  output logic    wr_valid,
  output cls_t    wr_data,
  input  logic    wr_ready
);

  assign in_ch.ready = wr_ready;
  assign wr_valid    = in_ch.valid;

  always_comb begin
    wr_data.start    = (in_ch.mode == MODE_START);
    wr_data.got      = (in_ch.mode == MODE_RX);
    wr_data.len_one  = (in_ch.rx_len == 4'd1);
    wr_data.len_two  = (in_ch.rx_len == 4'd2);
    wr_data.len_five = (in_ch.rx_len == 4'd5);
    wr_data.crc_ok   = in_ch.crc_ok;
    wr_data.rx_data  = in_ch.rx_data;
  end

endmodule

/* rtl/core/nfca_queue.sv */
// Short FIFO between the classifying front end and the protocol back end.
module nfca_queue import nfca_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cls_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output cls_t rd_data,
  input  logic rd_ready
);

  cls_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;
  logic                   push;
  logic                   pop;

  assign wr_ready = (fill != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/nfca_back.sv */
// Back end: activation sequencer, UID collection and registered result stage.
module nfca_back import nfca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] cascade_tag_value,
  input  logic [7:0] select_code_base,
  input  logic       rd_valid,
  input  cls_t       rd_data,
  output logic       rd_ready,
  nfca_out_if.source out_ch
);

  logic [2:0]          phase, phase_next;
  logic [1:0]          level, level_next;
  logic [3:0]          uid_count, uid_count_next;
  logic [15:0]         atqa, atqa_next;
  logic [7:0]          sak, sak_next;
  logic [31:0]         held_id, held_id_next;
  logic [UID_BITS-1:0] uid_vec, uid_vec_next, uid_masked;

  logic                out_valid;
  logic                emit;
  logic [1:0]          kind;
  logic [2:0]          tx_len;
  logic [55:0]         tx_data;
  logic [2:0]          status;

  logic                wr_en;
  logic [2:0]          wr_n;
  logic [31:0]         wr_src;
  logic [7:0]          sel_now;
  logic [7:0]          sel_up;
  logic [1:0]          ofs;
  logic                is_tag;
  logic                take;

  assign rd_ready     = !out_valid || out_ch.ready;
  assign take         = rd_valid && rd_ready;
  assign out_ch.valid = out_valid;

  assign sel_now = select_code_base + {5'd0, level, 1'b0};
  assign sel_up  = select_code_base + {5'd0, level + 2'd1, 1'b0};
  assign is_tag  = (held_id[7:0] == cascade_tag_value);

  always_comb begin
    phase_next     = phase;
    level_next     = level;
    uid_count_next = uid_count;
    atqa_next      = atqa;
    sak_next       = sak;
    held_id_next   = held_id;
    emit           = 1'b1;
    kind           = KIND_NONE;
    tx_len         = 3'd0;
    tx_data        = '0;
    status         = STAT_BUSY;
    wr_en          = 1'b0;
    wr_n           = 3'd4;
    wr_src         = held_id;

    if (rd_data.start) begin
      level_next     = '0;
      uid_count_next = '0;
      atqa_next      = '0;
      sak_next       = '0;
      if (phase != PH_IDLE && phase != PH_SENS) begin
        phase_next = PH_HALT;
        kind       = KIND_STD;
        tx_len     = LEN_HLTA;
        tx_data    = {40'd0, HLTA_B1, HLTA_B0};
      end else begin
        phase_next = PH_SENS;
        kind       = KIND_SENS;
      end
    end else begin
      case (phase)
        PH_HALT: begin
          phase_next = PH_SENS;
          kind       = KIND_SENS;
        end
        PH_SENS: begin
          if (!rd_data.got) begin
            phase_next = PH_IDLE;
            status     = STAT_NOT_FOUND;
          end else if (!rd_data.len_two) begin
            phase_next = PH_IDLE;
            status     = STAT_COMM_ERR;
          end else begin
            atqa_next  = rd_data.rx_data[15:0];
            level_next = '0;
            phase_next = PH_SDD;
            kind       = KIND_SDD;
            tx_len     = LEN_SDD;
            tx_data    = {40'd0, SDD_PAR, select_code_base};
          end
        end
        PH_SDD: begin
          if (!rd_data.got || !rd_data.len_five) begin
            phase_next = PH_FAILED;
            status     = STAT_COLL_FAIL;
          end else begin
            held_id_next = rd_data.rx_data[31:0];
            phase_next   = PH_SEL;
            kind         = KIND_STD;
            tx_len       = LEN_SEL;
            tx_data      = {rd_data.rx_data, SEL_PAR, sel_now};
          end
        end
        PH_SEL: begin
          if (!rd_data.got || !rd_data.crc_ok || !rd_data.len_one) begin
            phase_next = PH_FAILED;
            status     = STAT_COLL_FAIL;
          end else if (is_tag) begin
            if ({3'd0, level} + 5'd1 >= 5'(MAX_CASCADE_LEVELS) ||
                {1'b0, uid_count} + 5'd3 > 5'(UID_MAX_BYTES)) begin
              phase_next = PH_FAILED;
              status     = STAT_COLL_FAIL;
            end else begin
              // Tag byte dropped: keep the three UID bytes after it
              wr_en          = 1'b1;
              wr_n           = 3'd3;
              wr_src         = {8'd0, held_id[31:8]};
              uid_count_next = uid_count + 4'd3;
              level_next     = level + 2'd1;
              phase_next     = PH_SDD;
              kind           = KIND_SDD;
              tx_len         = LEN_SDD;
              tx_data        = {40'd0, SDD_PAR, sel_up};
            end
          end else if ({1'b0, uid_count} + 5'd4 > 5'(UID_MAX_BYTES)) begin
            phase_next = PH_FAILED;
            status     = STAT_COLL_FAIL;
          end else begin
            wr_en          = 1'b1;
            uid_count_next = uid_count + 4'd4;
            sak_next       = rd_data.rx_data[7:0];
            phase_next     = PH_ACTIVE;
            status         = STAT_ACTIVE;
          end
        end
        default: begin
          // Stray outcome while idle, active or failed: drop it
          emit = 1'b0;
        end
      endcase
    end
  end

  // Place new UID bytes at the current fill point, then hide bytes past the count
  always_comb begin
    uid_vec_next = uid_vec;
    uid_masked   = '0;
    ofs          = '0;
    for (int b = 0; b < UID_MAX_BYTES; b++) begin
      ofs = 2'(4'(b) - uid_count);
      if (wr_en && 4'(b) >= uid_count &&
          5'(b) < {1'b0, uid_count} + {2'd0, wr_n}) begin
        uid_vec_next[b*8 +: 8] = wr_src[{ofs, 3'b000} +: 8];
      end
      if (4'(b) < uid_count_next) begin
        uid_masked[b*8 +: 8] = uid_vec_next[b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      level     <= '0;
      uid_count <= '0;
      atqa      <= '0;
      sak       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        level     <= level_next;
        uid_count <= uid_count_next;
        atqa      <= atqa_next;
        sak       <= sak_next;
        out_valid <= emit;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      uid_vec <= uid_vec_next;
      held_id <= held_id_next;
      if (emit) begin
        out_ch.tx_kind        <= kind;
        out_ch.tx_len         <= tx_len;
        out_ch.tx_data        <= tx_data;
        out_ch.status         <= status;
        out_ch.uid_low_bytes  <= uid_masked[63:0];
        out_ch.uid_high_bytes <= uid_masked[79:64];
        out_ch.uid_length     <= uid_count_next;
        out_ch.sak_value      <= sak_next;
        out_ch.atqa_value     <= atqa_next;
      end
    end
  end

endmodule

/* rtl/core/nfca_anticollision_activation_unit.sv */
// Top level of the ISO14443A poller activation block (anticollision and select).
// Throughput: one transfer outcome per cycle, sustained, while results are taken.
// Path: each accepted input passes through a queue slot, then the result register.
// Each input gives one result, except a stray outcome while idle, active or failed.
// Reset (rst, synchronous): phase idle, level and UID count zero, ATQA/SAK zero,
// queue empty, registers at 0x88 / 0x93; UID bytes are not cleared and need no pass.
module nfca_anticollision_activation_unit import nfca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  nfca_in_if.sink    in_ch,
  nfca_out_if.source out_ch
);

  // Configuration registers; the user must write them only while no transfer is in flight (not enforced here)
  logic [7:0] cascade_tag_value;
  logic [7:0] select_code_base;

  // Front-to-queue and queue-to-back channels
  logic wr_valid;
  logic wr_ready;
  cls_t wr_data;
  logic rd_valid;
  logic rd_ready;
  cls_t rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cascade_tag_value <= CASCADE_TAG_RESET;
      select_code_base  <= SELECT_BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CASCADE_TAG: cascade_tag_value <= cfg_data;
        REG_SELECT_BASE: select_code_base  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Decode mode, length and CRC flags of each accepted transfer
  nfca_front u_front (
    .in_ch    (in_ch),
    .wr_valid (wr_valid),
    .wr_data  (wr_data),
    .wr_ready (wr_ready)
  );

  // Hold classified outcomes so a stalled result does not block intake
  nfca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_data  (wr_data),
    .wr_ready (wr_ready),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .rd_ready (rd_ready)
  );

  // Advance the activation sequence and drive the result register
  nfca_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cascade_tag_value (cascade_tag_value),
    .select_code_base  (select_code_base),
    .rd_valid          (rd_valid),
    .rd_data           (rd_data),
    .rd_ready          (rd_ready),
    .out_ch            (out_ch)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ISO14443A activation unit: directed and random transfers.
`timescale 1ns / 1ps

module testbench;
  import nfca_pkg::*;

  // Transfer outcome codes that the package does not name
  localparam logic [1:0] MODE_TIMEOUT  = 2'd2;
  localparam logic [1:0] MODE_XFER_ERR = 2'd3;

  localparam int DRAIN_CYCLES   = 8;       // margin after the last predicted result
  localparam int LIMIT_CYCLES   = 200000;
  localparam int PLAN_STEPS     = 6;       // register settings visited
  localparam int RESULTS_PER    = 325;     // results per register setting
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  rx_len;
    logic [39:0] rx_data;
    logic        crc_ok;
  } poller_item_t;

  typedef struct packed {
    logic [1:0]  tx_kind;
    logic [2:0]  tx_len;
    logic [55:0] tx_data;
    logic [2:0]  status;
    logic [63:0] uid_low_bytes;
    logic [15:0] uid_high_bytes;
    logic [3:0]  uid_length;
    logic [7:0]  sak_value;
    logic [15:0] atqa_value;
  } poll_result_t;

  // Tracks the poller state, predicts the frame or status each transfer
  // causes and holds those predictions until the block delivers them.
  class activation_tracker;
    logic [7:0]   tag_cfg;
    logic [7:0]   base_cfg;
    logic [2:0]   phase;
    int unsigned  level;
    logic [7:0]   uid [UID_MAX_BYTES];
    int unsigned  uid_count;
    logic [31:0]  held_id;
    logic [15:0]  atqa;
    logic [7:0]   sak;
    poll_result_t pending_frames[$];
    int failures;
    int n_results, n_active, n_long_uid, n_absent, n_comm, n_collision;

    function new();
      tag_cfg   = CASCADE_TAG_RESET;
      base_cfg  = SELECT_BASE_RESET;
      phase     = PH_IDLE;
      level     = 0;
      uid_count = 0;
      held_id   = '0;
      atqa      = '0;
      sak       = '0;
      failures  = 0;
      n_results = 0; n_active = 0; n_long_uid = 0;
      n_absent  = 0; n_comm = 0; n_collision = 0;
      foreach (uid[i]) uid[i] = '0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      if (idx == REG_CASCADE_TAG) tag_cfg = value;
      else base_cfg = value;
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function logic [7:0] select_code();
      return base_cfg + 8'(2 * level);
    endfunction

    // Build a result from the current held values
    function poll_result_t compose(logic [1:0] kind, logic [2:0] len, logic [55:0] data,
                                   logic [2:0] st);
      poll_result_t r;
      r = '0;
      r.tx_kind    = kind;
      r.tx_len     = len;
      r.tx_data    = data;
      r.status     = st;
      r.uid_length = 4'(uid_count);
      r.sak_value  = sak;
      r.atqa_value = atqa;
      for (int i = 0; i < uid_count; i++) begin
        if (i < 8) r.uid_low_bytes[8*i +: 8] = uid[i];
        else r.uid_high_bytes[8*(i-8) +: 8] = uid[i];
      end
      case (st)
        STAT_ACTIVE: begin
          n_active++;
          if (uid_count > 4) n_long_uid++;
        end
        STAT_NOT_FOUND: n_absent++;
        STAT_COMM_ERR:  n_comm++;
        STAT_COLL_FAIL: n_collision++;
        default: ;
      endcase
      return r;
    endfunction

    function poll_result_t sdd_frame();
      phase = PH_SDD;
      return compose(KIND_SDD, LEN_SDD, {40'd0, SDD_PAR, select_code()}, STAT_BUSY);
    endfunction

    function poll_result_t collision_failure();
      phase = PH_FAILED;
      return compose(KIND_NONE, 3'd0, 56'd0, STAT_COLL_FAIL);
    endfunction

    // Advance the poller on one accepted transfer; return 1 if it yields a result
    function bit predict_outcome(poller_item_t it);
      poll_result_t r;
      bit got;
      bit engaged;
      got = (it.mode == MODE_RX);
      if (it.mode == MODE_START) begin
        engaged   = (phase != PH_IDLE) && (phase != PH_SENS);
        level     = 0;
        uid_count = 0;
        atqa      = '0;
        sak       = '0;
        if (engaged) begin
          phase = PH_HALT;
          r = compose(KIND_STD, LEN_HLTA, {40'd0, HLTA_B1, HLTA_B0}, STAT_BUSY);
        end else begin
          phase = PH_SENS;
          r = compose(KIND_SENS, 3'd0, 56'd0, STAT_BUSY);
        end
      end else begin
        case (phase)
          PH_HALT: begin
            phase = PH_SENS;
            r = compose(KIND_SENS, 3'd0, 56'd0, STAT_BUSY);
          end
          PH_SENS: begin
            if (!got) begin
              phase = PH_IDLE;
              r = compose(KIND_NONE, 3'd0, 56'd0, STAT_NOT_FOUND);
            end else if (it.rx_len != 4'd2) begin
              phase = PH_IDLE;
              r = compose(KIND_NONE, 3'd0, 56'd0, STAT_COMM_ERR);
            end else begin
              atqa  = it.rx_data[15:0];
              level = 0;
              r = sdd_frame();
            end
          end
          PH_SDD: begin
            if (!got || it.rx_len != 4'd5) begin
              r = collision_failure();
            end else begin
              held_id = it.rx_data[31:0];
              phase   = PH_SEL;
              r = compose(KIND_STD, LEN_SEL, {it.rx_data, SEL_PAR, select_code()}, STAT_BUSY);
            end
          end
          PH_SEL: begin
            if (!got || !it.crc_ok || it.rx_len != 4'd1) begin
              r = collision_failure();
            end else if (held_id[7:0] == tag_cfg) begin
              if (level + 1 >= MAX_CASCADE_LEVELS || uid_count + 3 > UID_MAX_BYTES) begin
                r = collision_failure();
              end else begin
                for (int k = 0; k < 3; k++) uid[uid_count + k] = held_id[8*(k+1) +: 8];
                uid_count += 3;
                level++;
                r = sdd_frame();
              end
            end else if (uid_count + 4 > UID_MAX_BYTES) begin
              r = collision_failure();
            end else begin
              for (int k = 0; k < 4; k++) uid[uid_count + k] = held_id[8*k +: 8];
              uid_count += 4;
              sak   = it.rx_data[7:0];
              phase = PH_ACTIVE;
              r = compose(KIND_NONE, 3'd0, 56'd0, STAT_ACTIVE);
            end
          end
          default: return 1'b0;   // stray outcome: ignored
        endcase
      end
      pending_frames.push_back(r);
      n_results++;
      return 1'b1;
    endfunction

    // Compare a delivered result with the oldest prediction
    function void check_response(poll_result_t seen);
      poll_result_t want;
      bit bad;
      if (pending_frames.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result with nothing predicted: kind %0d status %0d data %h",
                   $time, seen.tx_kind, seen.status, seen.tx_data);
        return;
      end
      want = pending_frames.pop_front();
      bad = (seen.tx_kind        !== want.tx_kind)        ||
            (seen.tx_len         !== want.tx_len)         ||
            (seen.tx_data        !== want.tx_data)        ||
            (seen.status         !== want.status)         ||
            (seen.uid_low_bytes  !== want.uid_low_bytes)  ||
            (seen.uid_high_bytes !== want.uid_high_bytes) ||
            (seen.uid_length     !== want.uid_length)     ||
            (seen.sak_value      !== want.sak_value)      ||
            (seen.atqa_value     !== want.atqa_value);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] mismatch (want/got): kind %0d/%0d len %0d/%0d data %h/%h",
                   $time, want.tx_kind, seen.tx_kind, want.tx_len, seen.tx_len,
                   want.tx_data, seen.tx_data);
          $display("  status %0d/%0d uid %h_%h/%h_%h ulen %0d/%0d sak %h/%h atqa %h/%h",
                   want.status, seen.status, want.uid_high_bytes, want.uid_low_bytes,
                   seen.uid_high_bytes, seen.uid_low_bytes, want.uid_length,
                   seen.uid_length, want.sak_value, seen.sak_value,
                   want.atqa_value, seen.atqa_value);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  nfca_in_if  in_ch();
  nfca_out_if out_ch();

  nfca_anticollision_activation_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  activation_tracker sb;
  bit quiet;            // no idling on either side while set
  bit pressure_armed;   // ask the result side for one long hold-off
  int cycles;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: fail the run once the total cycle count passes the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: take results, check them, and throttle ready at random.
  // The long hold-off is counted here so the sender keeps offering meanwhile.
  initial begin : result_sink
    int  hold;
    bit  held_once;
    hold      = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_response('{out_ch.tx_kind, out_ch.tx_len, out_ch.tx_data, out_ch.status,
                            out_ch.uid_low_bytes, out_ch.uid_high_bytes, out_ch.uid_length,
                            out_ch.sak_value, out_ch.atqa_value});
      if (pressure_armed && !held_once) begin
        hold      = HOLD_OFF_CYCLES;
        held_once = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Offer one transfer, idling at random first; hold it
  // until accepted, then advance the tracker in acceptance order.
  task automatic push_item(input poller_item_t it, output bit gives_result);
    while (!quiet && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= it.mode;
    in_ch.rx_len  <= it.rx_len;
    in_ch.rx_data <= it.rx_data;
    in_ch.crc_ok  <= it.crc_ok;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gives_result = sb.predict_outcome(it);
  endtask

  task automatic send(input logic [1:0] mode, input logic [3:0] len,
                      input logic [39:0] data, input logic crc);
    bit unused;
    push_item('{mode, len, data, crc}, unused);
  endtask

  // Drop valid and wait until every predicted result has arrived, plus margin
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only called while idle
  task automatic write_regs(input logic [7:0] tag, input logic [7:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CASCADE_TAG;
    cfg_data  <= tag;
    @(posedge clk);
    cfg_index <= REG_SELECT_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(REG_CASCADE_TAG, tag);
    sb.write_reg(REG_SELECT_BASE, base);
    settings_used++;
  endtask

  // Shape a transfer that mostly answers what the poller just sent, so that
  // runs reach the deeper cascade levels; the rest is noise and broken replies.
  function automatic poller_item_t make_item();
    poller_item_t it;
    logic [63:0]  w;
    int           r;
    w = {$urandom, $urandom};
    it.mode    = MODE_RX;
    it.rx_len  = 4'd0;
    it.rx_data = w[39:0];
    it.crc_ok  = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 4) begin
      it.mode = MODE_START;                          // abort whatever is going on
      return it;
    end
    if (r < 14) begin
      it.mode   = 2'($urandom_range(3));
      it.rx_len = 4'($urandom_range(15));
      return it;
    end
    case (sb.phase)
      PH_HALT: begin                                 // any halt outcome moves on
        it.mode   = 2'($urandom_range(1, 3));
        it.rx_len = 4'($urandom_range(15));
      end
      PH_SENS: begin
        if (r < 20) it.mode = 2'($urandom_range(2, 3));
        else if (r < 26) it.rx_len = 4'($urandom_range(15));
        else it.rx_len = 4'd2;
      end
      PH_SDD: begin
        if (r < 20) it.mode = 2'($urandom_range(2, 3));
        else if (r < 26) it.rx_len = 4'($urandom_range(15));
        else it.rx_len = 4'd5;
        // Mark a further cascade level about half of the time
        if ($urandom_range(99) < 50) it.rx_data[7:0] = sb.tag_cfg;
      end
      PH_SEL: begin
        if (r < 18) it.mode = 2'($urandom_range(2, 3));
        else if (r < 22) it.rx_len = 4'($urandom_range(15));
        else it.rx_len = 4'd1;
        if (r >= 22 && r < 26) it.crc_ok = 1'b0;
        else if (r >= 26) it.crc_ok = 1'b1;
      end
      default: begin                                 // idle, active or failed
        if (r < 25) begin
          it.mode   = 2'($urandom_range(1, 3));      // stray outcome
          it.rx_len = 4'($urandom_range(15));
        end else begin
          it.mode = MODE_START;
        end
      end
    endcase
    return it;
  endfunction

  initial begin : stimulus
    bit          counted;
    int          produced;
    logic [63:0] w;
    sb             = new();
    quiet          = 1'b0;
    pressure_armed = 1'b0;
    cycles         = 0;
    settings_used  = 1;
    // Drive every input to a known value before the first edge
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_CASCADE_TAG;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_START;
    in_ch.rx_len  <= '0;
    in_ch.rx_data <= '0;
    in_ch.crc_ok  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, registers at reset values
    send(MODE_RX, 4'd2, 40'h0, 1'b1);                  // stray while idle: no result
    send(MODE_START, 4'd0, 40'h0, 1'b0);               // SENS_REQ
    send(MODE_TIMEOUT, 4'd0, 40'h0, 1'b0);             // no card: not present
    send(MODE_START, 4'd0, 40'h0, 1'b0);
    send(MODE_XFER_ERR, 4'd15, 40'hFF_FFFF_FFFF, 1'b1); // transfer error: not present
    send(MODE_START, 4'd0, 40'h0, 1'b0);
    send(MODE_RX, 4'd3, 40'h00_0000_0044, 1'b1);       // ATQA of wrong length
    // Cascade tag at every level, the last one too many
    send(MODE_START, 4'd0, 40'h0, 1'b0);
    send(MODE_RX, 4'd2, 40'hFF_FFFF_FFFF, 1'b0);
    send(MODE_RX, 4'd5, 40'hA1_B2_C3_D4_88, 1'b1);
    send(MODE_RX, 4'd1, 40'h00_0000_0004, 1'b1);
    send(MODE_RX, 4'd5, 40'h11_2233_4488, 1'b1);
    send(MODE_RX, 4'd1, 40'h00_0000_0004, 1'b1);
    send(MODE_RX, 4'd5, 40'h55_6677_0088, 1'b1);
    send(MODE_RX, 4'd1, 40'h00_0000_0000, 1'b1);       // collision failure
    // Engaged start halts first; then a SAK with a bad CRC
    send(MODE_START, 4'd0, 40'h0, 1'b0);
    send(MODE_TIMEOUT, 4'd0, 40'h0, 1'b0);
    send(MODE_RX, 4'd2, 40'h00_0000_0000, 1'b0);
    send(MODE_RX, 4'd5, 40'h00_0000_0000, 1'b0);
    send(MODE_RX, 4'd1, 40'h00_0000_0008, 1'b0);
    // Full single-size activation with all-ones bytes
    send(MODE_START, 4'd0, 40'h0, 1'b0);
    send(MODE_RX, 4'd15, 40'hFF_FFFF_FFFF, 1'b1);
    send(MODE_RX, 4'd2, 40'h00_0000_0044, 1'b1);
    send(MODE_RX, 4'd5, 40'hFF_FFFF_FFFF, 1'b1);
    send(MODE_RX, 4'd1, 40'hFF_FFFF_FFFF, 1'b1);       // activated
    w = {$urandom, $urandom};
    send(MODE_RX, 4'd1, w[39:0], 1'b1);                // stray while active
    settle();

    // Random part over several register settings, the extremes among them
    for (int p = 0; p < PLAN_STEPS; p++) begin
      case (p)
        1: write_regs(8'h00, 8'h00);
        2: write_regs(8'hFF, 8'hFF);
        3: write_regs(CASCADE_TAG_RESET, 8'hFE);        // select code wraps
        4: write_regs(8'($urandom_range(255)), 8'($urandom_range(255)));
        5: write_regs(CASCADE_TAG_RESET, SELECT_BASE_RESET);
        default: ;
      endcase
      quiet    = (p == 2);
      produced = 0;
      while (produced < RESULTS_PER) begin
        if (p == 3 && produced == 80) pressure_armed = 1'b1;
        push_item(make_item(), counted);
        if (counted) produced++;
      end
      settle();
    end
    quiet = 1'b0;

    $display("covered %0d results over %0d register settings (%0d cycles)",
             sb.n_results, settings_used, cycles);
    $display("outcomes: %0d activated (%0d with 7 or 10 byte UID), %0d absent, %0d errors, %0d %s",
             sb.n_active, sb.n_long_uid, sb.n_absent, sb.n_comm, sb.n_collision,
             "collisions");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
